// File: design/lcsb_pkg.sv
// ----------------------------------------------------------------------------
// lcsb_pkg
// Shared constants and types for the Lua comment and string blanker.
// ----------------------------------------------------------------------------
package lcsb_pkg;

  // Range of the long-bracket level parameter.
  localparam int MAX_LEVEL_DEFAULT = 15;
  localparam int MAX_LEVEL_LIMIT   = 31;

  // A run covers at most the opener's equals signs plus its two brackets.
  localparam int RUN_W = $clog2(MAX_LEVEL_LIMIT + 3);

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;

  // Compact form of all output words caused by one input byte:
  // an optional head byte, a run of one repeated byte, an optional tail byte.
  typedef struct packed {
    logic             head_v;
    logic [7:0]       head;
    logic [RUN_W-1:0] run_cnt;
    logic [7:0]       run_byte;
    logic             tail_v;
    logic [7:0]       tail;
    logic             last;
  } lcsb_desc_t;

endpackage

// File: design/lcsb_ifs.sv
// ----------------------------------------------------------------------------
// lcsb stream interfaces
// Valid/ready channels for source bytes and for blanked output bytes.
// ----------------------------------------------------------------------------
interface lcsb_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       src_last;

  modport source (output valid, output src_byte, output src_last, input ready);
  modport sink   (input valid, input src_byte, input src_last, output ready);
endinterface

interface lcsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: design/lcsb_scanner.sv
// ----------------------------------------------------------------------------
// lcsb_scanner
// Input register and scan state; turns each byte into an output descriptor.
// ----------------------------------------------------------------------------
module lcsb_scanner
  import lcsb_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  lcsb_src_if.sink    src,
  input  logic        emit_free,
  output logic        desc_load,
  output lcsb_desc_t  desc
);

  localparam int LW = $clog2(MAX_LEVEL + 1);

  typedef enum logic [2:0] {
    M_NORMAL, M_DASH, M_DASHES, M_OPENER, M_LONG, M_QUOTE, M_LINE
  } mode_t;

  logic          in_v;
  logic [7:0]    in_byte;
  logic          in_last;

  mode_t         mode, mode_next;
  logic [LW-1:0] opener_eq, opener_eq_next;
  logic          after_dashes, after_dashes_next;
  logic [LW-1:0] body_level, body_level_next;
  logic          close_armed, close_armed_next;
  logic [LW-1:0] close_eq, close_eq_next;
  logic          quote_dq, quote_dq_next;
  logic          esc_pend, esc_pend_next;

  logic          go_normal;
  logic          desc_empty;
  logic          advance;
  lcsb_desc_t    d;

  always_comb begin
    mode_next         = mode;
    opener_eq_next    = opener_eq;
    after_dashes_next = after_dashes;
    body_level_next   = body_level;
    close_armed_next  = close_armed;
    close_eq_next     = close_eq;
    quote_dq_next     = quote_dq;
    esc_pend_next     = esc_pend;
    go_normal         = 1'b0;
    d                 = '0;
    d.run_byte        = CH_SP;
    d.last            = in_last;

    unique case (mode)
      M_DASH: begin
        if (in_byte == CH_DASH) begin
          mode_next = M_DASHES;
          d.run_cnt = RUN_W'(2);
        end else begin
          d.head_v  = 1'b1;
          d.head    = CH_DASH;
          go_normal = 1'b1;
        end
      end
      M_DASHES: begin
        d.tail_v = 1'b1;
        if (in_byte == CH_LBR) begin
          mode_next         = M_OPENER;
          after_dashes_next = 1'b1;
          opener_eq_next    = '0;
          d.tail            = CH_SP;
        end else if (in_byte == CH_NL) begin
          mode_next = M_NORMAL;
          d.tail    = CH_NL;
        end else begin
          mode_next = M_LINE;
          d.tail    = CH_SP;
        end
      end
      M_OPENER: begin
        if (after_dashes) begin
          d.tail_v = 1'b1;
          d.tail   = CH_SP;
          if (in_byte == CH_EQ && opener_eq < LW'(MAX_LEVEL)) begin
            opener_eq_next = opener_eq + LW'(1);
          end else if (in_byte == CH_LBR) begin
            mode_next         = M_LONG;
            body_level_next   = opener_eq;
            close_armed_next  = 1'b0;
            close_eq_next     = '0;
            opener_eq_next    = '0;
            after_dashes_next = 1'b0;
          end else begin
            // A newline ends the comment; anything else makes it a line comment.
            mode_next         = (in_byte == CH_NL) ? M_NORMAL : M_LINE;
            opener_eq_next    = '0;
            after_dashes_next = 1'b0;
            if (in_byte == CH_NL) begin
              d.tail = CH_NL;
            end
          end
        end else begin
          if (in_byte == CH_EQ && opener_eq < LW'(MAX_LEVEL)) begin
            opener_eq_next = opener_eq + LW'(1);
          end else if (in_byte == CH_LBR) begin
            d.run_cnt         = RUN_W'(opener_eq) + RUN_W'(2);
            mode_next         = M_LONG;
            body_level_next   = opener_eq;
            close_armed_next  = 1'b0;
            close_eq_next     = '0;
            opener_eq_next    = '0;
            after_dashes_next = 1'b0;
          end else begin
            // Not an opener after all: release the held bracket and equals.
            d.head_v       = 1'b1;
            d.head         = CH_LBR;
            d.run_cnt      = RUN_W'(opener_eq);
            d.run_byte     = CH_EQ;
            opener_eq_next = '0;
            go_normal      = 1'b1;
          end
        end
      end
      M_LONG: begin
        d.tail_v = 1'b1;
        d.tail   = (in_byte == CH_NL) ? CH_NL : CH_SP;
        if (close_armed) begin
          if (in_byte == CH_EQ) begin
            if (close_eq < body_level) begin
              close_eq_next = close_eq + LW'(1);
            end else begin
              close_armed_next = 1'b0;
            end
          end else if (in_byte == CH_RBR) begin
            if (close_eq == body_level) begin
              mode_next        = M_NORMAL;
              body_level_next  = '0;
              close_armed_next = 1'b0;
            end
            close_eq_next = '0;
          end else begin
            close_armed_next = 1'b0;
            close_eq_next    = '0;
          end
        end else if (in_byte == CH_RBR) begin
          close_armed_next = 1'b1;
          close_eq_next    = '0;
        end
      end
      M_QUOTE: begin
        d.tail_v = 1'b1;
        d.tail   = CH_SP;
        if (esc_pend) begin
          esc_pend_next = 1'b0;
          if (in_byte == CH_NL) begin
            d.tail = CH_NL;
          end
        end else if (in_byte == (quote_dq ? CH_DQ : CH_SQ)) begin
          mode_next     = M_NORMAL;
          quote_dq_next = 1'b0;
        end else if (in_byte == CH_NL) begin
          mode_next     = M_NORMAL;
          quote_dq_next = 1'b0;
          d.tail        = CH_NL;
        end else if (in_byte == CH_BSL) begin
          esc_pend_next = 1'b1;
        end
      end
      M_LINE: begin
        d.tail_v = 1'b1;
        if (in_byte == CH_NL) begin
          mode_next = M_NORMAL;
          d.tail    = CH_NL;
        end else begin
          d.tail = CH_SP;
        end
      end
      default: begin
        go_normal = 1'b1;
      end
    endcase

    if (go_normal) begin
      mode_next = M_NORMAL;
      if (in_byte == CH_DASH) begin
        mode_next = M_DASH;
      end else if (in_byte == CH_LBR) begin
        mode_next         = M_OPENER;
        after_dashes_next = 1'b0;
        opener_eq_next    = '0;
      end else if (in_byte == CH_SQ || in_byte == CH_DQ) begin
        mode_next     = M_QUOTE;
        quote_dq_next = (in_byte == CH_DQ);
        esc_pend_next = 1'b0;
        d.tail_v      = 1'b1;
        d.tail        = CH_SP;
      end else begin
        d.tail_v = 1'b1;
        d.tail   = in_byte;
      end
    end

    // The final byte releases whatever is held and returns to reset state.
    // Held text never shares a slot with what the same byte already emitted.
    if (in_last) begin
      if (mode_next == M_DASH) begin
        d.tail_v = 1'b1;
        d.tail   = CH_DASH;
      end else if (mode_next == M_OPENER && !after_dashes_next) begin
        if (opener_eq_next == '0) begin
          d.tail_v = 1'b1;
          d.tail   = CH_LBR;
        end else begin
          d.head_v   = 1'b1;
          d.head     = CH_LBR;
          d.run_cnt  = RUN_W'(opener_eq_next);
          d.run_byte = CH_EQ;
        end
      end
      mode_next         = M_NORMAL;
      opener_eq_next    = '0;
      after_dashes_next = 1'b0;
      body_level_next   = '0;
      close_armed_next  = 1'b0;
      close_eq_next     = '0;
      quote_dq_next     = 1'b0;
      esc_pend_next     = 1'b0;
    end
  end

  assign desc_empty = !(d.head_v || d.tail_v || (d.run_cnt != '0));
  assign advance    = in_v && (emit_free || desc_empty);
  assign desc_load  = advance && !desc_empty;
  assign desc       = d;
  assign src.ready  = !in_v || advance;

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      in_byte <= src.src_byte;
      in_last <= src.src_last;
    end
    if (rst) begin
      in_v         <= 1'b0;
      mode         <= M_NORMAL;
      opener_eq    <= '0;
      after_dashes <= 1'b0;
      body_level   <= '0;
      close_armed  <= 1'b0;
      close_eq     <= '0;
      quote_dq     <= 1'b0;
      esc_pend     <= 1'b0;
    end else begin
      if (src.valid && src.ready) begin
        in_v <= 1'b1;
      end else if (advance) begin
        in_v <= 1'b0;
      end
      if (advance) begin
        mode         <= mode_next;
        opener_eq    <= opener_eq_next;
        after_dashes <= after_dashes_next;
        body_level   <= body_level_next;
        close_armed  <= close_armed_next;
        close_eq     <= close_eq_next;
        quote_dq     <= quote_dq_next;
        esc_pend     <= esc_pend_next;
      end
    end
  end

endmodule

// File: design/lcsb_emitter.sv
// ----------------------------------------------------------------------------
// lcsb_emitter
// Result register; plays out one descriptor as a sequence of output words.
// ----------------------------------------------------------------------------
module lcsb_emitter
  import lcsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lcsb_desc_t  desc,
  input  logic        desc_load,
  output logic        emit_free,
  lcsb_out_if.source  out
);

  lcsb_desc_t cur;
  logic       has_run;
  logic       pending;
  logic       final_word;
  logic       take;

  assign has_run    = (cur.run_cnt != '0);
  assign pending    = cur.head_v || has_run || cur.tail_v;
  assign final_word = (cur.head_v && !has_run && !cur.tail_v)
                   || (!cur.head_v && cur.run_cnt == RUN_W'(1) && !cur.tail_v)
                   || (!cur.head_v && !has_run && cur.tail_v);
  assign take       = pending && out.ready;
  assign emit_free  = !pending || (final_word && out.ready);

  assign out.valid    = pending;
  assign out.out_byte = cur.head_v ? cur.head : (has_run ? cur.run_byte : cur.tail);
  assign out.out_last = cur.last && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.head_v  <= 1'b0;
      cur.run_cnt <= '0;
      cur.tail_v  <= 1'b0;
    end else if (emit_free) begin
      if (desc_load) begin
        cur <= desc;
      end else begin
        cur.head_v  <= 1'b0;
        cur.run_cnt <= '0;
        cur.tail_v  <= 1'b0;
      end
    end else if (take) begin
      // Consume head first, then the run, then the tail.
      if (cur.head_v) begin
        cur.head_v <= 1'b0;
      end else if (has_run) begin
        cur.run_cnt <= cur.run_cnt - RUN_W'(1);
      end else begin
        cur.tail_v <= 1'b0;
      end
    end
  end

endmodule

// File: design/lua_comment_string_blanker_core.sv
// Registers: a source byte is taken into the input register; its result words are offered from the output register.
// Throughput: one source byte per cycle while each byte yields at most one word and the output is not stalled;
// a byte that yields more words (released lookahead, blanked brackets) holds the
// output register until its last word is taken, and the input stalls behind it.
// Reset: synchronous, active high; clears scan state and both registers.
// ----------------------------------------------------------------------------
// lua_comment_string_blanker_core
// Replaces Lua comment and string bytes with spaces, keeping newlines.
// ----------------------------------------------------------------------------
module lua_comment_string_blanker_core
  import lcsb_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  lcsb_src_if.sink    src,
  lcsb_out_if.source  out
);

  lcsb_desc_t desc;
  logic       desc_load;
  logic       emit_free;

  lcsb_scanner #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_scanner (
    .clk       (clk),
    .rst       (rst),
    .src       (src),
    .emit_free (emit_free),
    .desc_load (desc_load),
    .desc      (desc)
  );

  lcsb_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .desc      (desc),
    .desc_load (desc_load),
    .emit_free (emit_free),
    .out       (out)
  );

endmodule

// File: design/lcsb_checker.sv
// ----------------------------------------------------------------------------
// lcsb_props
// Port-level checks on the blanker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lcsb_props
  import lcsb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       src_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled output word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // Quote characters are always blanked, whether they open or close a string or sit in a comment.
  a_no_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_byte != CH_SQ) && (out_byte != CH_DQ))
    else $error("quote character passed through");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> src_ready)
    else $error("input not ready right after reset");

endmodule

bind lua_comment_string_blanker_core lcsb_props u_lcsb_props (
  .clk       (clk),
  .rst       (rst),
  .src_ready (src.ready),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .out_byte  (out.out_byte),
  .out_last  (out.out_last)
);
